// ----- sv/fbt_pkg.sv -----
// Shared types, constants and helper functions for the FNV-1a base-36 tag block.
package fbt_pkg;

	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

	localparam int TAG_RADIX = 36;
	localparam int TAG_LEN   = 6;
	localparam int CHAR_W    = 7;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
	localparam logic [5:0]        NUM_DIGITS = 6'd10;

	typedef logic [CHAR_W-1:0] char_t;
	typedef char_t [TAG_LEN-1:0] tag_t;

	// One FNV-1a step. The prime is 2^40 + 0x1B3, so the product is a sum of shifts.
	function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	// Maps a base-36 digit to its ASCII character.
	function automatic char_t digit_char(logic [5:0] d);
		char_t c;
		if (d < NUM_DIGITS) begin
			c = CHAR_ZERO + char_t'(d);
		end else begin
			c = CHAR_A + char_t'(d - NUM_DIGITS);
		end
		return c;
	endfunction

endpackage

// ----- sv/fbt_if.sv -----
// Valid/ready channel interfaces for string bytes in and tags out.
interface fbt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, data_byte, has_byte, last, input ready);
	modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface fbt_out_if;
	logic           valid;
	logic           ready;
	fbt_pkg::char_t code_char_0;
	fbt_pkg::char_t code_char_1;
	fbt_pkg::char_t code_char_2;
	fbt_pkg::char_t code_char_3;
	fbt_pkg::char_t code_char_4;
	fbt_pkg::char_t code_char_5;

	modport source (output valid, code_char_0, code_char_1, code_char_2, code_char_3,
		code_char_4, code_char_5, input ready);
	modport sink (input valid, code_char_0, code_char_1, code_char_2, code_char_3,
		code_char_4, code_char_5, output ready);
endinterface

// ----- sv/fbt_tag.sv -----
// Pipelined reduction of a 64-bit hash modulo 36^6 into six base-36 ASCII characters.
module fbt_tag (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hash_vld,
	output logic          hash_rdy,
	input  logic [63:0]   hash,
	output logic          tag_vld,
	input  logic          tag_rdy,
	output fbt_pkg::tag_t tag
);

	localparam int NUM_STAGES = 11;
	localparam int LANES      = 2;

	// 36^6 = 2^12 * 3^12 and 36^3 = 2^6 * 3^6.
	localparam longint unsigned FULL_MOD  = longint'(fbt_pkg::TAG_RADIX) ** fbt_pkg::TAG_LEN;
	localparam longint unsigned HALF_MOD  = longint'(fbt_pkg::TAG_RADIX) ** (fbt_pkg::TAG_LEN / 2);
	localparam longint unsigned QUAD_MOD  = longint'(fbt_pkg::TAG_RADIX) ** 2;
	localparam longint unsigned FULL_ODD  = FULL_MOD >> 12;
	localparam longint unsigned HALF_ODD  = HALF_MOD >> 6;

	localparam logic [72:0] RECIP_FULL_W = (73'd1 << 72) / 73'(FULL_ODD);
	localparam logic [52:0] RECIP_FULL   = 53'(RECIP_FULL_W);
	localparam logic [20:0] RECIP_HI     = RECIP_FULL[52:32];
	localparam logic [31:0] RECIP_LO     = RECIP_FULL[31:0];
	localparam logic [26:0] RECIP_HALF   = 27'(((64'd1 << 36) + 64'(HALF_ODD) - 64'd1) /
		64'(HALF_ODD));
	localparam logic [16:0] RECIP_QUAD   = 17'(((64'd1 << 27) + 64'(QUAD_MOD) - 64'd1) /
		64'(QUAD_MOD));
	localparam logic [11:0] RECIP_RADIX  = 12'(((64'd1 << 17) + 64'(fbt_pkg::TAG_RADIX) -
		64'd1) / 64'(fbt_pkg::TAG_RADIX));

	localparam logic [20:0] ODD21    = 21'(FULL_ODD);
	localparam logic [25:0] HODD26   = 26'(HALF_ODD);
	localparam logic [15:0] QUAD16   = 16'(QUAD_MOD);
	localparam logic [10:0] RADIX11  = 11'(fbt_pkg::TAG_RADIX);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] rdy;
	logic [NUM_STAGES-1:0] ld;
	logic [NUM_STAGES-1:0] vld_in;

	assign rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || tag_rdy;
	for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign vld_in = {vld_q[NUM_STAGES-2:0], hash_vld};
	assign ld     = vld_in & rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign hash_rdy = rdy[0];
	assign tag_vld  = vld_q[NUM_STAGES-1];

	logic [63:0] h_s1;
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			h_s1 <= hash;
		end
	end

	// Quotient estimate of (hash >> 12) / 3^12 from three partial products.
	logic [40:0] m_hh;
	logic [51:0] m_hl;
	logic [52:0] m_lh;
	logic [28:0] phh_s2;
	logic [51:0] phl_s2;
	logic [52:0] plh_s2;
	logic [20:0] y21_s2;
	logic [11:0] low12_s2;

	assign m_hh = 41'(h_s1[63:44]) * 41'(RECIP_HI);
	assign m_hl = 52'(h_s1[63:44]) * 52'(RECIP_LO);
	assign m_lh = 53'(h_s1[43:12]) * 53'(RECIP_HI);

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			phh_s2   <= m_hh[28:0];
			phl_s2   <= m_hl;
			plh_s2   <= m_lh;
			y21_s2   <= h_s1[32:12];
			low12_s2 <= h_s1[11:0];
		end
	end

	logic [60:0] qsum;
	logic [20:0] q21_s3;
	logic [20:0] y21_s3;
	logic [11:0] low12_s3;

	assign qsum = {phh_s2, 32'd0} + 61'(phl_s2) + 61'(plh_s2);

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			q21_s3   <= qsum[60:40];
			y21_s3   <= y21_s2;
			low12_s3 <= low12_s2;
		end
	end

	logic [40:0] m_qn;
	logic [20:0] qn_s4;
	logic [20:0] y21_s4;
	logic [11:0] low12_s4;

	assign m_qn = 41'(q21_s3) * 41'(ODD21);

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			qn_s4    <= m_qn[20:0];
			y21_s4   <= y21_s3;
			low12_s4 <= low12_s3;
		end
	end

	// The estimate is at most one short, so one conditional subtract finishes the remainder.
	logic [20:0] rdiff;
	logic [20:0] rfix;
	logic [25:0] u_s5;
	logic [5:0]  low6_s5;

	assign rdiff = y21_s4 - qn_s4;
	assign rfix  = (rdiff >= ODD21) ? rdiff - ODD21 : rdiff;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			u_s5    <= {rfix[19:0], low12_s4[11:6]};
			low6_s5 <= low12_s4[5:0];
		end
	end

	// Split the tag value into two halves of three digits each.
	logic [52:0] m_u;
	logic [15:0] hi_s6;
	logic [25:0] u_s6;
	logic [5:0]  low6_s6;

	assign m_u = 53'(u_s5) * 53'(RECIP_HALF);

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			hi_s6   <= m_u[51:36];
			u_s6    <= u_s5;
			low6_s6 <= low6_s5;
		end
	end

	logic [25:0] m_h;
	logic [25:0] umod;
	logic [15:0] part_s7 [LANES];

	assign m_h  = 26'(hi_s6) * HODD26;
	assign umod = u_s6 - m_h;

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			part_s7[0] <= hi_s6;
			part_s7[1] <= {umod[9:0], low6_s6};
		end
	end

	logic [32:0] m_a     [LANES];
	logic [5:0]  top_s8  [LANES];
	logic [15:0] part_s8 [LANES];
	logic [15:0] m_t     [LANES];
	logic [15:0] rdiff9  [LANES];
	logic [5:0]  top_s9  [LANES];
	logic [10:0] rem_s9  [LANES];
	logic [22:0] m_b     [LANES];
	logic [5:0]  top_s10 [LANES];
	logic [5:0]  mid_s10 [LANES];
	logic [10:0] rem_s10 [LANES];
	logic [10:0] m_m     [LANES];
	logic [10:0] ldiff   [LANES];
	fbt_pkg::tag_t tag_s11;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			m_a[l]    = 33'(part_s7[l]) * 33'(RECIP_QUAD);
			m_t[l]    = 16'(top_s8[l]) * QUAD16;
			rdiff9[l] = part_s8[l] - m_t[l];
			m_b[l]    = 23'(rem_s9[l]) * 23'(RECIP_RADIX);
			m_m[l]    = 11'(mid_s10[l]) * RADIX11;
			ldiff[l]  = rem_s10[l] - m_m[l];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			for (int l = 0; l < LANES; l++) begin
				top_s8[l]  <= m_a[l][32:27];
				part_s8[l] <= part_s7[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			for (int l = 0; l < LANES; l++) begin
				top_s9[l] <= top_s8[l];
				rem_s9[l] <= rdiff9[l][10:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[9]) begin
			for (int l = 0; l < LANES; l++) begin
				top_s10[l] <= top_s9[l];
				mid_s10[l] <= m_b[l][22:17];
				rem_s10[l] <= rem_s9[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[10]) begin
			for (int l = 0; l < LANES; l++) begin
				tag_s11[3*l]     <= fbt_pkg::digit_char(top_s10[l]);
				tag_s11[3*l + 1] <= fbt_pkg::digit_char(mid_s10[l]);
				tag_s11[3*l + 2] <= fbt_pkg::digit_char(ldiff[l][5:0]);
			end
		end
	end

	assign tag = tag_s11;

endmodule

// ----- sv/fnv1a64_base36_tag.sv -----
// Top level: running FNV-1a 64-bit string hash emitted as a six-character base-36 tag.
//
// The byte_in channel carries one string byte per beat (data_byte, qualified by
// has_byte) and the last flag that ends a string. The hash register takes one
// beat per cycle while byte_in.ready is high; the per-byte XOR and prime multiply
// are a single shift-add stage feeding that register. A beat with last set sends
// the final hash into an eleven-stage reduction pipeline, and the tag appears on
// tag_out from the last stage register. Tags leave at up to one per cycle while
// tag_out.ready is high. Beats without last produce no tag.
// Reset returns the hash to the FNV offset basis and empties the pipeline.
// When the receiver stalls, the finished tag stays in the output register and
// earlier pipeline stages keep filling, so byte_in stays ready until every stage
// holds a tag; byte_in.ready is always high while tag_out.valid is low.
module fnv1a64_base36_tag (
	input logic        clk,
	input logic        arst_n,
	fbt_in_if.sink     byte_in,
	fbt_out_if.source  tag_out
);

	logic [63:0]   hash_q;
	logic [63:0]   hash_upd;
	logic          accept;
	logic          tag_rdy;
	fbt_pkg::tag_t tag;

	assign accept   = byte_in.valid && byte_in.ready;
	assign hash_upd = byte_in.has_byte ? fbt_pkg::fnv_step(hash_q, byte_in.data_byte) : hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= fbt_pkg::FNV_BASIS;
		end else if (accept) begin
			hash_q <= byte_in.last ? fbt_pkg::FNV_BASIS : hash_upd;
		end
	end

	fbt_tag u_tag (
		.clk      (clk),
		.arst_n   (arst_n),
		.hash_vld (byte_in.valid && byte_in.last),
		.hash_rdy (tag_rdy),
		.hash     (hash_upd),
		.tag_vld  (tag_out.valid),
		.tag_rdy  (tag_out.ready),
		.tag      (tag)
	);

	assign byte_in.ready       = tag_rdy;
	assign tag_out.code_char_0 = tag[0];
	assign tag_out.code_char_1 = tag[1];
	assign tag_out.code_char_2 = tag[2];
	assign tag_out.code_char_3 = tag[3];
	assign tag_out.code_char_4 = tag[4];
	assign tag_out.code_char_5 = tag[5];

endmodule

// ----- sv/fbt_checker.sv -----
// Port-level assertions for the tag block and the bind that attaches them.
module fbt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [6*fbt_pkg::CHAR_W-1:0]      code_chars
);

	logic chars_ok;

	always_comb begin
		chars_ok = 1'b1;
		for (int i = 0; i < fbt_pkg::TAG_LEN; i++) begin
			if (!((code_chars[i*fbt_pkg::CHAR_W +: fbt_pkg::CHAR_W] >= 7'd48 &&
				code_chars[i*fbt_pkg::CHAR_W +: fbt_pkg::CHAR_W] <= 7'd57) ||
				(code_chars[i*fbt_pkg::CHAR_W +: fbt_pkg::CHAR_W] >= 7'd65 &&
				code_chars[i*fbt_pkg::CHAR_W +: fbt_pkg::CHAR_W] <= 7'd90))) begin
				chars_ok = 1'b0;
			end
		end
	end

	// Every character of a presented tag is a digit or an upper-case letter.
	a_chars_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chars_ok)
		else $error("tag character outside 0-9 and A-Z");

	// With no tag waiting, the pipeline has room and the input side is open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while no tag is pending");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("tag withdrawn before it was taken");

	a_tag_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(code_chars))
		else $error("tag changed while stalled");

endmodule

bind fnv1a64_base36_tag fbt_checker u_fbt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (byte_in.ready),
	.out_valid  (tag_out.valid),
	.out_ready  (tag_out.ready),
	.code_chars ({tag_out.code_char_5, tag_out.code_char_4, tag_out.code_char_3,
		tag_out.code_char_2, tag_out.code_char_1, tag_out.code_char_0})
);

// ----- test/fnv1a64_base36_tag_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the FNV-1a 64-bit base-36 tag block: byte stream in, predicted tags checked out.
module fnv1a64_base36_tag_tb;

	localparam logic [63:0] HASH_MULT    = 64'd1099511628211;
	localparam logic [63:0] TAG_MODULUS  = 64'd2176782336;
	localparam logic [63:0] RADIX        = 64'd36;
	localparam int          NUM_BEATS    = 1250;
	localparam int          QUIET_TAIL   = 120;
	localparam int          PARK_AT      = 400;
	localparam int          PARK_CYCLES  = 200;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          CYCLE_LIMIT  = 400000;

	typedef struct {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
		bit         hold;
	} byte_beat_t;

	logic clk;
	logic arst_n;

	fbt_in_if  byte_in();
	fbt_out_if tag_out();

	fnv1a64_base36_tag u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.tag_out (tag_out)
	);

	byte_beat_t     pending_beats[$];
	fbt_pkg::tag_t  expected_tags[$];
	logic [63:0]    running_hash = fbt_pkg::FNV_BASIS;
	bit             beat_taken;
	bit             in_busy;
	bit             quiet_tail;
	int             beats_taken;
	int             tags_seen;
	int             mismatches;
	int             cycles;

	function automatic fbt_pkg::tag_t hash_to_tag(logic [63:0] h);
		logic [63:0]   rem;
		logic [5:0]    d;
		fbt_pkg::tag_t t;
		rem = h % TAG_MODULUS;
		for (int k = fbt_pkg::TAG_LEN - 1; k >= 0; k--) begin
			d = 6'(rem % RADIX);
			rem = rem / RADIX;
			if (d < fbt_pkg::NUM_DIGITS) begin
				t[k] = fbt_pkg::CHAR_ZERO + fbt_pkg::char_t'(d);
			end else begin
				t[k] = fbt_pkg::CHAR_A + fbt_pkg::char_t'(d - fbt_pkg::NUM_DIGITS);
			end
		end
		return t;
	endfunction

	task automatic add_beat(logic [7:0] b, logic hb, logic lst, bit hold = 0);
		byte_beat_t bt;
		bt.data_byte = b;
		bt.has_byte  = hb;
		bt.last      = lst;
		bt.hold      = hold;
		pending_beats.push_back(bt);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		byte_in.valid = 1'b0;
		byte_in.data_byte = 8'h00;
		byte_in.has_byte = 1'b0;
		byte_in.last = 1'b0;
		tag_out.ready = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL fnv1a64_base36_tag");
		$finish;
	end

	// Output check runs before the input prediction so that no beat can match a tag of its own edge.
	always @(posedge clk) begin
		fbt_pkg::tag_t got;
		fbt_pkg::tag_t want;
		beat_taken = 1'b0;
		if (arst_n) begin
			if (tag_out.valid && tag_out.ready) begin
				got[0] = tag_out.code_char_0;
				got[1] = tag_out.code_char_1;
				got[2] = tag_out.code_char_2;
				got[3] = tag_out.code_char_3;
				got[4] = tag_out.code_char_4;
				got[5] = tag_out.code_char_5;
				if (expected_tags.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("tag %0d: unexpected tag %c%c%c%c%c%c", tags_seen,
							got[0], got[1], got[2], got[3], got[4], got[5]);
					end
				end else begin
					want = expected_tags.pop_front();
					for (int k = 0; k < fbt_pkg::TAG_LEN; k++) begin
						if (got[k] !== want[k]) begin
							mismatches++;
							if (mismatches <= 10) begin
								$display("tag %0d code_char_%0d: expected %c (%0d), got %c (%0d)",
									tags_seen, k, want[k], want[k], got[k], got[k]);
							end
						end
					end
				end
				tags_seen++;
			end
			if (byte_in.valid && byte_in.ready) begin
				beat_taken = 1'b1;
				if (byte_in.has_byte || byte_in.last) beats_taken++;
				if (byte_in.has_byte) begin
					running_hash = (running_hash ^ {56'd0, byte_in.data_byte}) * HASH_MULT;
				end
				if (byte_in.last) begin
					expected_tags.push_back(hash_to_tag(running_hash));
					running_hash = fbt_pkg::FNV_BASIS;
				end
			end
		end
	end

	always @(negedge clk) begin
		byte_beat_t bt;
		int         gap_left;
		int         loaded;
		int         idle_pct;
		if (arst_n) begin
			if (in_busy && beat_taken) in_busy = 1'b0;
			if (!in_busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_beats.size() > 0 &&
					!(pending_beats[0].hold && expected_tags.size() != 0)) begin
					bt = pending_beats.pop_front();
					byte_in.data_byte <= bt.data_byte;
					byte_in.has_byte <= bt.has_byte;
					byte_in.last <= bt.last;
					in_busy = 1'b1;
					quiet_tail = pending_beats.size() < QUIET_TAIL;
					if (loaded % 100 == 0) begin
						case ($urandom_range(0, 2))
							0: idle_pct = 0;
							1: idle_pct = 10;
							default: idle_pct = 35;
						endcase
					end
					loaded++;
					if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
						gap_left = $urandom_range(1, 16);
					end
				end
			end
			byte_in.valid <= in_busy;
		end
	end

	always @(negedge clk) begin
		int stall_left;
		int park_left;
		bit park_done;
		int stall_pct;
		int ticks;
		logic rdy;
		if (arst_n) begin
			if (ticks % 128 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end
			ticks++;
			if (park_left > 0) begin
				park_left--;
				rdy = 1'b0;
			end else if (!park_done && beats_taken >= PARK_AT) begin
				park_done = 1'b1;
				park_left = PARK_CYCLES - 1;
				rdy = 1'b0;
			end else if (quiet_tail) begin
				rdy = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 16);
			end
			tag_out.ready <= rdy;
		end
	end

	initial begin
		int   counted;
		int   len;
		bit   marked;
		logic joined;

		add_beat(8'h5A, 1'b0, 1'b1);
		add_beat(8'hFF, 1'b0, 1'b0);
		add_beat(8'h61, 1'b1, 1'b1);
		add_beat(8'hFF, 1'b1, 1'b0);
		add_beat(8'hA5, 1'b0, 1'b1);
		add_beat(8'h00, 1'b1, 1'b0);
		add_beat(8'h00, 1'b1, 1'b1);
		add_beat(8'h00, 1'b0, 1'b1);
		add_beat(8'hFF, 1'b0, 1'b1);
		add_beat(8'h66, 1'b1, 1'b0);
		add_beat(8'h6F, 1'b1, 1'b0);
		add_beat(8'h6F, 1'b1, 1'b0);
		add_beat(8'h62, 1'b1, 1'b0);
		add_beat(8'h61, 1'b1, 1'b0);
		add_beat(8'h72, 1'b1, 1'b1);
		add_beat(8'h78, 1'b1, 1'b0);
		add_beat(8'h3C, 1'b0, 1'b0);
		add_beat(8'h79, 1'b1, 1'b1);
		add_beat(8'h80, 1'b1, 1'b0);
		add_beat(8'h7F, 1'b1, 1'b0);
		add_beat(8'h01, 1'b1, 1'b1);
		add_beat(8'hC3, 1'b0, 1'b1);

		counted = 0;
		marked = 0;
		while (counted < NUM_BEATS) begin
			if ($urandom_range(0, 99) < 5) begin
				add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end else begin
				if ($urandom_range(0, 99) < 3) len = $urandom_range(40, 120);
				else len = $urandom_range(0, 8);
				joined = len > 0 && $urandom_range(0, 1) == 1;
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 4) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
					add_beat(pick_byte(), 1'b1, joined && i == len - 1,
						(counted == 0 || (!marked && counted >= NUM_BEATS / 2)) && i == 0);
					if (counted >= NUM_BEATS / 2 && i == 0) marked = 1;
					counted++;
				end
				if (!joined) begin
					add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, counted == 0);
					counted++;
				end
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || in_busy || expected_tags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_tags.size() == 0) begin
			$display("PASS fnv1a64_base36_tag");
		end else begin
			$display("FAIL fnv1a64_base36_tag");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/fbt_pkg.sv
sv/fbt_if.sv
sv/fbt_tag.sv
sv/fnv1a64_base36_tag.sv
sv/fbt_checker.sv
test/fnv1a64_base36_tag_tb.sv
